/* rtl/vpfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpfa_pkg
// Shared types and constants of the free-list placement allocator.
// ----------------------------------------------------------------------------
package vpfa_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int SIZE_W      = 10;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [0:0] REG_POLICY = 1'b0;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_ALLOC  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;

  typedef enum logic [2:0] {
    STS_LOADED  = 3'd0,
    STS_PLACED  = 3'd1,
    STS_PERFECT = 3'd2,
    STS_NOFIT   = 3'd3,
    STS_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_SHIFT,
    S_RESP
  } fsm_t;

  typedef struct packed {
    logic              ge;
    logic              lt;
    logic              zero;
    logic [SIZE_W-1:0] diff;
  } alu_res_t;

endpackage

/* rtl/vpfa_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpfa_alu
// Shared compare and subtract unit used by the scan and the update steps.
// ----------------------------------------------------------------------------
module vpfa_alu (
  input  logic [vpfa_pkg::SIZE_W-1:0] a,
  input  logic [vpfa_pkg::SIZE_W-1:0] b,
  input  logic [vpfa_pkg::SIZE_W-1:0] c,
  output vpfa_pkg::alu_res_t          res
);

  logic [vpfa_pkg::SIZE_W-1:0] diff;

  assign diff     = a - b;
  assign res.ge   = (a >= b);
  assign res.lt   = (a < c);
  assign res.zero = (diff == '0);
  assign res.diff = diff;

endmodule

/* rtl/variable_partition_fit_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_fit_allocator
// Free-list allocator with first fit, next fit and best fit placement.
// ----------------------------------------------------------------------------
// append, clear: from idle straight to the response state, no scan
// allocate: one region read per cycle through the shared compare unit in the scan,
//   then the update step, then a shift of later entries down on a perfect fit
// one item at a time: in_stall is high outside the idle state
// reset: policy first fit, list empty, next pointer 0; region store not cleared
module variable_partition_fit_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic [vpfa_pkg::SIZE_W-1:0]       in_size,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_status,
  output logic [vpfa_pkg::IDX_W-1:0]        out_region_index,
  output logic [vpfa_pkg::SIZE_W-1:0]       out_remaining,
  output logic [vpfa_pkg::CNT_W-1:0]        out_region_count,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vpfa_pkg::APB_AW-1:0]       paddr,
  input  logic [vpfa_pkg::APB_DW-1:0]       pwdata,
  output logic [vpfa_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int IW = vpfa_pkg::IDX_W;
  localparam int CW = vpfa_pkg::CNT_W;
  localparam int SW = vpfa_pkg::SIZE_W;

  vpfa_pkg::fsm_t    state_r, state_nxt;
  vpfa_pkg::status_t res_status_r, res_status_nxt;

  logic [1:0]    policy_r, policy_nxt;
  logic [IW-1:0] nptr_r, nptr_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic          chk_last_r, chk_last_nxt;
  logic          best_v_r, best_v_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [SW-1:0] best_size_r, best_size_nxt;
  logic [IW-1:0] res_idx_r, res_idx_nxt;
  logic [SW-1:0] res_rem_r, res_rem_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [IW-1:0] out_idx_r, out_idx_nxt;
  logic [SW-1:0] out_rem_r, out_rem_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;

  logic [SW-1:0] mem [vpfa_pkg::MAX_REGIONS];
  logic [SW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [SW-1:0] mem_wd;

  logic [SW-1:0]      alu_a, alu_b, alu_c;
  vpfa_pkg::alu_res_t alu_res;

  logic cfg_wr;
  logic is_next;
  logic is_best;

  vpfa_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .res (alu_res)
  );

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == vpfa_pkg::REG_POLICY) ?
                   {{(vpfa_pkg::APB_DW-2){1'b0}}, policy_r} : '0;
  assign is_next = (policy_r == vpfa_pkg::POL_NEXT);
  assign is_best = (policy_r == vpfa_pkg::POL_BEST);

  assign in_stall         = (state_r != vpfa_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_region_index = out_idx_r;
  assign out_remaining    = out_rem_r;
  assign out_region_count = out_count_r;

  // region store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vpfa_pkg::S_IDLE;
      policy_r    <= vpfa_pkg::POL_FIRST;
      nptr_r      <= '0;
      live_r      <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      nptr_r      <= nptr_nxt;
      live_r      <= live_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    k_r          <= k_nxt;
    n_r          <= n_nxt;
    chk_idx_r    <= chk_idx_nxt;
    chk_last_r   <= chk_last_nxt;
    best_v_r     <= best_v_nxt;
    best_idx_r   <= best_idx_nxt;
    best_size_r  <= best_size_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_rem_r    <= res_rem_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_rem_r    <= out_rem_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    policy_nxt     = policy_r;
    nptr_nxt       = nptr_r;
    live_nxt       = live_r;
    size_nxt       = size_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    chk_v_nxt      = chk_v_r;
    chk_idx_nxt    = chk_idx_r;
    chk_last_nxt   = chk_last_r;
    best_v_nxt     = best_v_r;
    best_idx_nxt   = best_idx_r;
    best_size_nxt  = best_size_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_rem_nxt    = res_rem_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_rem_nxt    = out_rem_r;
    out_count_nxt  = out_count_r;
    rd_addr        = k_r;
    mem_we         = 1'b0;
    mem_wa         = chk_idx_r;
    mem_wd         = rd_data_r;
    alu_a          = rd_data_r;
    alu_b          = size_r;
    alu_c          = best_size_r;

    if (cfg_wr && (paddr[2] == vpfa_pkg::REG_POLICY)) begin
      policy_nxt = pwdata[1:0];
      nptr_nxt   = '0;
    end

    case (state_r)
      vpfa_pkg::S_IDLE: begin
        if (in_valid) begin
          size_nxt    = in_size;
          res_idx_nxt = '0;
          res_rem_nxt = '0;
          state_nxt   = vpfa_pkg::S_RESP;
          case (in_mode)
            vpfa_pkg::MODE_APPEND: begin
              if (live_r == CW'(vpfa_pkg::MAX_REGIONS)) begin
                res_status_nxt = vpfa_pkg::STS_FULL;
              end else begin
                mem_we         = 1'b1;
                mem_wa         = live_r[IW-1:0];
                mem_wd         = in_size;
                live_nxt       = live_r + CW'(1);
                res_status_nxt = vpfa_pkg::STS_LOADED;
                res_idx_nxt    = live_r[IW-1:0];
              end
            end
            vpfa_pkg::MODE_ALLOC: begin
              if (live_r == '0) begin
                res_status_nxt = vpfa_pkg::STS_NOFIT;
              end else begin
                k_nxt      = (is_next && (CW'(nptr_r) < live_r)) ? nptr_r : '0;
                n_nxt      = '0;
                chk_v_nxt  = 1'b0;
                best_v_nxt = 1'b0;
                state_nxt  = vpfa_pkg::S_SCAN;
              end
            end
            vpfa_pkg::MODE_CLEAR: begin
              live_nxt       = '0;
              res_status_nxt = vpfa_pkg::STS_LOADED;
            end
            default: begin
              res_status_nxt = vpfa_pkg::STS_LOADED;
            end
          endcase
        end
      end

      vpfa_pkg::S_SCAN: begin
        chk_v_nxt = 1'b0;
        if (n_r < live_r) begin
          rd_addr      = k_r;
          k_nxt        = ((CW'(k_r) + CW'(1)) == live_r) ? '0 : k_r + IW'(1);
          n_nxt        = n_r + CW'(1);
          chk_v_nxt    = 1'b1;
          chk_idx_nxt  = k_r;
          chk_last_nxt = ((n_r + CW'(1)) == live_r);
        end
        if (chk_v_r) begin
          if (is_best) begin
            if (alu_res.ge && (!best_v_r || alu_res.lt)) begin
              best_v_nxt    = 1'b1;
              best_idx_nxt  = chk_idx_r;
              best_size_nxt = rd_data_r;
            end
            if (chk_last_r) begin
              chk_v_nxt = 1'b0;
              if (best_v_r || alu_res.ge) begin
                state_nxt = vpfa_pkg::S_APPLY;
              end else begin
                res_status_nxt = vpfa_pkg::STS_NOFIT;
                state_nxt      = vpfa_pkg::S_RESP;
              end
            end
          end else if (alu_res.ge) begin
            best_idx_nxt  = chk_idx_r;
            best_size_nxt = rd_data_r;
            if (is_next) begin
              nptr_nxt = chk_idx_r;
            end
            chk_v_nxt = 1'b0;
            state_nxt = vpfa_pkg::S_APPLY;
          end else if (chk_last_r) begin
            chk_v_nxt      = 1'b0;
            res_status_nxt = vpfa_pkg::STS_NOFIT;
            state_nxt      = vpfa_pkg::S_RESP;
          end
        end
      end

      vpfa_pkg::S_APPLY: begin
        alu_a       = best_size_r;
        res_idx_nxt = best_idx_r;
        if (!alu_res.zero) begin
          mem_we         = 1'b1;
          mem_wa         = best_idx_r;
          mem_wd         = alu_res.diff;
          res_status_nxt = vpfa_pkg::STS_PLACED;
          res_rem_nxt    = alu_res.diff;
          state_nxt      = vpfa_pkg::S_RESP;
        end else begin
          res_status_nxt = vpfa_pkg::STS_PERFECT;
          res_rem_nxt    = '0;
          if ((CW'(best_idx_r) + CW'(1)) < live_r) begin
            n_nxt     = CW'(best_idx_r) + CW'(1);
            chk_v_nxt = 1'b0;
            state_nxt = vpfa_pkg::S_SHIFT;
          end else begin
            live_nxt  = live_r - CW'(1);
            state_nxt = vpfa_pkg::S_RESP;
          end
        end
      end

      vpfa_pkg::S_SHIFT: begin
        chk_v_nxt = 1'b0;
        if (n_r < live_r) begin
          rd_addr      = n_r[IW-1:0];
          n_nxt        = n_r + CW'(1);
          chk_v_nxt    = 1'b1;
          chk_idx_nxt  = n_r[IW-1:0];
          chk_last_nxt = ((n_r + CW'(1)) == live_r);
        end
        if (chk_v_r) begin
          mem_we = 1'b1;
          mem_wa = chk_idx_r - IW'(1);
          mem_wd = rd_data_r;
          if (chk_last_r) begin
            chk_v_nxt = 1'b0;
            live_nxt  = live_r - CW'(1);
            state_nxt = vpfa_pkg::S_RESP;
          end
        end
      end

      vpfa_pkg::S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_rem_nxt    = res_rem_r;
          out_count_nxt  = live_r;
          state_nxt      = vpfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = vpfa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/vpfa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpfa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module vpfa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [2:0]                  out_status,
  input logic [vpfa_pkg::IDX_W-1:0]  out_region_index,
  input logic [vpfa_pkg::SIZE_W-1:0] out_remaining,
  input logic [vpfa_pkg::CNT_W-1:0]  out_region_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_region_index) && $stable(out_remaining) && $stable(out_region_count))
    else $error("stalled result changed");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_region_count <= vpfa_pkg::CNT_W'(vpfa_pkg::MAX_REGIONS))
    else $error("region count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(vpfa_pkg::STS_FULL)) |->
      out_region_count == vpfa_pkg::CNT_W'(vpfa_pkg::MAX_REGIONS))
    else $error("list full reported with free entries");

  a_rem_placed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(vpfa_pkg::STS_PLACED)) |-> out_remaining != '0)
    else $error("placed with zero remainder");

  a_rem_other: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 3'(vpfa_pkg::STS_PLACED)) |-> out_remaining == '0)
    else $error("remainder on a result without placement");

endmodule

bind variable_partition_fit_allocator vpfa_checker u_vpfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_region_index (out_region_index),
  .out_remaining    (out_remaining),
  .out_region_count (out_region_count)
);

/* dv/tb_variable_partition_fit_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_variable_partition_fit_allocator
// Self-checking bench for the free-list placement allocator. A directed table
// walks appends, allocations, clears, a full list and each placement policy.
// Random traffic follows under a series of policy settings, with random idle
// bursts on both channels in all phases but the last. Every result is compared
// field by field against typed table values or a behavioral free-list model.
// ----------------------------------------------------------------------------
module tb_variable_partition_fit_allocator;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] POL_UNUSED  = 2'd3;
  localparam logic [vpfa_pkg::APB_AW-1:0] ADDR_POLICY =
    vpfa_pkg::APB_AW'(4 * vpfa_pkg::REG_POLICY);
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 2 * vpfa_pkg::MAX_REGIONS + 10;
  localparam int RANDOM_ITEMS  = 1010;
  localparam int NUM_PHASES    = 6;
  localparam int NUM_ROWS      = 25;

  localparam logic [1:0] PHASE_POLICY [NUM_PHASES] =
    '{vpfa_pkg::POL_FIRST, vpfa_pkg::POL_NEXT, vpfa_pkg::POL_BEST, POL_UNUSED,
      vpfa_pkg::POL_NEXT, vpfa_pkg::POL_BEST};
  localparam int PHASE_APPEND_PCT [NUM_PHASES] = '{45, 75, 55, 60, 50, 65};

  typedef struct packed {
    vpfa_pkg::status_t           status;
    logic [vpfa_pkg::IDX_W-1:0]  idx;
    logic [vpfa_pkg::SIZE_W-1:0] rem;
    logic [vpfa_pkg::CNT_W-1:0]  cnt;
  } placement_t;

  typedef enum logic {ROW_ITEM, ROW_POLICY} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [1:0]                  code;   // mode for items, policy for register rows
    logic [vpfa_pkg::SIZE_W-1:0] size;
    logic [4:0]                  reps;
    logic                        typed;
    placement_t                  want;
  } stim_row_t;

  localparam placement_t NONE = '{vpfa_pkg::STS_LOADED, '0, '0, '0};

  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd5, 5'd1, 1'b1,
      '{vpfa_pkg::STS_NOFIT, 4'd0, 10'd0, 5'd0}},
    '{ROW_ITEM, vpfa_pkg::MODE_APPEND, 10'd1023, 5'd1, 1'b1,
      '{vpfa_pkg::STS_LOADED, 4'd0, 10'd0, 5'd1}},
    '{ROW_ITEM, vpfa_pkg::MODE_APPEND, 10'd0, 5'd1, 1'b1,
      '{vpfa_pkg::STS_LOADED, 4'd1, 10'd0, 5'd2}},
    '{ROW_ITEM, vpfa_pkg::MODE_APPEND, 10'd1, 5'd1, 1'b1,
      '{vpfa_pkg::STS_LOADED, 4'd2, 10'd0, 5'd3}},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd1023, 5'd1, 1'b1,
      '{vpfa_pkg::STS_PERFECT, 4'd0, 10'd0, 5'd2}},
    '{ROW_ITEM, MODE_UNUSED, 10'd1023, 5'd1, 1'b1,
      '{vpfa_pkg::STS_LOADED, 4'd0, 10'd0, 5'd2}},
    '{ROW_POLICY, vpfa_pkg::POL_BEST, 10'd0, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_APPEND, 10'd700, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_APPEND, 10'd600, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd0, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd550, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd40, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_APPEND, 10'd10, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd10, 5'd1, 1'b0, NONE},
    '{ROW_POLICY, vpfa_pkg::POL_NEXT, 10'd0, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd5, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd695, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd11, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd1, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_CLEAR, 10'd1023, 5'd1, 1'b1,
      '{vpfa_pkg::STS_LOADED, 4'd0, 10'd0, 5'd0}},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd1, 5'd1, 1'b1,
      '{vpfa_pkg::STS_NOFIT, 4'd0, 10'd0, 5'd0}},
    '{ROW_POLICY, POL_UNUSED, 10'd0, 5'd1, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_APPEND, 10'd1023, 5'd16, 1'b0, NONE},
    '{ROW_ITEM, vpfa_pkg::MODE_APPEND, 10'd5, 5'd1, 1'b1,
      '{vpfa_pkg::STS_FULL, 4'd0, 10'd0, 5'd16}},
    '{ROW_ITEM, vpfa_pkg::MODE_ALLOC, 10'd1023, 5'd1, 1'b1,
      '{vpfa_pkg::STS_PERFECT, 4'd0, 10'd0, 5'd15}}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_mode = vpfa_pkg::MODE_APPEND;
  logic [vpfa_pkg::SIZE_W-1:0]   in_size = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [2:0]                    out_status;
  logic [vpfa_pkg::IDX_W-1:0]    out_region_index;
  logic [vpfa_pkg::SIZE_W-1:0]   out_remaining;
  logic [vpfa_pkg::CNT_W-1:0]    out_region_count;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [vpfa_pkg::APB_AW-1:0]   paddr = '0;
  logic [vpfa_pkg::APB_DW-1:0]   pwdata = '0;
  logic [vpfa_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  // free-list model
  logic [vpfa_pkg::SIZE_W-1:0]   free_sizes [vpfa_pkg::MAX_REGIONS];
  int                            free_count = 0;
  logic [vpfa_pkg::IDX_W-1:0]    scan_ptr = '0;
  logic [1:0]                    fit_policy = vpfa_pkg::POL_FIRST;

  placement_t                    pending_placements [$];
  int                            failures = 0;
  int                            items_sent = 0;
  int                            policy_writes = 0;
  int                            status_seen [8];
  int                            quiet_cycles = 0;
  bit                            idle_on = 1'b1;

  variable_partition_fit_allocator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_size          (in_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_region_index (out_region_index),
    .out_remaining    (out_remaining),
    .out_region_count (out_region_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  function automatic placement_t compute_placement(
      input logic [1:0] mode, input logic [vpfa_pkg::SIZE_W-1:0] size);
    placement_t r;
    int pick;
    int start;
    int k;
    r = NONE;
    pick = -1;
    case (mode)
      vpfa_pkg::MODE_APPEND: begin
        if (free_count == vpfa_pkg::MAX_REGIONS) begin
          r.status = vpfa_pkg::STS_FULL;
        end else begin
          free_sizes[free_count] = size;
          r.idx = vpfa_pkg::IDX_W'(free_count);
          free_count++;
        end
      end
      vpfa_pkg::MODE_ALLOC: begin
        if (free_count > 0) begin
          if (fit_policy == vpfa_pkg::POL_NEXT) begin
            start = (int'(scan_ptr) < free_count) ? int'(scan_ptr) : 0;
            for (int i = 0; i < free_count; i++) begin
              k = (start + i) % free_count;
              if (pick < 0 && free_sizes[k] >= size) pick = k;
            end
            if (pick >= 0) scan_ptr = vpfa_pkg::IDX_W'(pick);
          end else if (fit_policy == vpfa_pkg::POL_BEST) begin
            for (int i = 0; i < free_count; i++) begin
              if (free_sizes[i] >= size && (pick < 0 || free_sizes[i] < free_sizes[pick]))
                pick = i;
            end
          end else begin
            for (int i = 0; i < free_count; i++) begin
              if (pick < 0 && free_sizes[i] >= size) pick = i;
            end
          end
        end
        if (pick < 0) begin
          r.status = vpfa_pkg::STS_NOFIT;
        end else if (free_sizes[pick] != size) begin
          free_sizes[pick] = free_sizes[pick] - size;
          r.status = vpfa_pkg::STS_PLACED;
          r.idx = vpfa_pkg::IDX_W'(pick);
          r.rem = free_sizes[pick];
        end else begin
          for (int j = pick; j < free_count - 1; j++) free_sizes[j] = free_sizes[j + 1];
          free_count--;
          r.status = vpfa_pkg::STS_PERFECT;
          r.idx = vpfa_pkg::IDX_W'(pick);
        end
      end
      vpfa_pkg::MODE_CLEAR: free_count = 0;
      default: ;
    endcase
    r.cnt = vpfa_pkg::CNT_W'(free_count);
    return r;
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [vpfa_pkg::SIZE_W-1:0] size,
                           input logic typed, input placement_t want);
    placement_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 19)) @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_size <= size;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = compute_placement(mode, size);
    pending_placements = {pending_placements, (typed ? want : predicted)};
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_policy(input logic [1:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_POLICY;
    pwdata <= vpfa_pkg::APB_DW'(value);
    @(negedge clk) penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    fit_policy = value;
    scan_ptr = '0;
    policy_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    if (prdata[1:0] !== value) begin
      $error("policy readback expected %0d got %0d", value, prdata[1:0]);
      failures++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random(input int append_pct);
    int roll;
    int pick;
    logic [1:0] mode;
    logic [vpfa_pkg::SIZE_W-1:0] size;
    logic [vpfa_pkg::SIZE_W-1:0] base;
    roll = $urandom_range(0, 99);
    size = vpfa_pkg::SIZE_W'($urandom_range(1, 1023));
    if (roll < 2) begin
      mode = vpfa_pkg::MODE_CLEAR;
    end else if (roll < 4) begin
      mode = MODE_UNUSED;
    end else if (roll < 4 + append_pct) begin
      mode = vpfa_pkg::MODE_APPEND;
      roll = $urandom_range(0, 9);
      if (roll == 0) size = '0;
      else if (roll < 4) size = vpfa_pkg::SIZE_W'($urandom_range(1, 31));
    end else begin
      mode = vpfa_pkg::MODE_ALLOC;
      roll = $urandom_range(0, 99);
      if (free_count == 0 || roll < 10) begin
        size = vpfa_pkg::SIZE_W'($urandom_range(0, 1023));
      end else begin
        pick = $urandom_range(0, free_count - 1);
        base = free_sizes[pick];
        if (roll < 45) size = base;
        else if (roll < 85) size = vpfa_pkg::SIZE_W'($urandom_range(0, base));
        else if (base != '1) size = base + 1'b1;
      end
    end
    send_item(mode, size, 1'b0, NONE);
  endtask

  // result side back-pressure
  initial begin
    @(posedge rst_n);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 19)) @(negedge clk) out_stall <= 1'b1;
      end else begin
        repeat ($urandom_range(1, 30)) @(negedge clk) out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_placements.size() == 0) begin
        $error("result transfer with nothing pending: status %0d index %0d",
               out_status, out_region_index);
        failures++;
      end else begin
        want = pending_placements.pop_front();
        status_seen[want.status]++;
        if (out_status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_status);
          failures++;
        end
        if (out_region_index !== want.idx) begin
          $error("region_index expected %0d got %0d", want.idx, out_region_index);
          failures++;
        end
        if (out_remaining !== want.rem) begin
          $error("remaining expected %0d got %0d", want.rem, out_remaining);
          failures++;
        end
        if (out_region_count !== want.cnt) begin
          $error("region_count expected %0d got %0d", want.cnt, out_region_count);
          failures++;
        end
      end
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("variable_partition_fit_allocator verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_POLICY) write_policy(row.code);
      else repeat (row.reps) send_item(row.code, row.size, row.typed, row.want);
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_policy(PHASE_POLICY[p]);
      idle_on = (p != NUM_PHASES - 1);
      repeat (RANDOM_ITEMS / NUM_PHASES) send_random(PHASE_APPEND_PCT[p]);
    end
    @(negedge clk) in_valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d transfers in over %0d policy writes: %0d loaded or cleared, %0d placed,",
             items_sent, policy_writes, status_seen[vpfa_pkg::STS_LOADED],
             status_seen[vpfa_pkg::STS_PLACED]);
    $display("%0d perfect fits, %0d no fit, %0d list full",
             status_seen[vpfa_pkg::STS_PERFECT], status_seen[vpfa_pkg::STS_NOFIT],
             status_seen[vpfa_pkg::STS_FULL]);
    if (failures == 0) begin
      $display("variable_partition_fit_allocator verification clean");
    end else begin
      $display("variable_partition_fit_allocator verification failed");
    end
    $finish;
  end

endmodule
